// ----- hw/rtl/mwmn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mwmn_pkg;

    // fraction bits of velocities and normalized wheel speeds
    localparam int FRAC_BITS  = 12;
    // fraction bits of the wheel-to-center distance
    localparam int DIST_FRAC  = 16;

    localparam int N_WHEEL    = 4;
    localparam int IN_W       = 16;
    localparam int SUM_W      = IN_W + 2;          // +-vx +-vy
    localparam int ROT_W      = 2 * IN_W + 1;      // d * wz
    localparam int WSUM_W     = SUM_W + DIST_FRAC; // exact mix
    localparam int MAG_W      = WSUM_W - 1;        // |mix|
    localparam int LIM_W      = 15;
    localparam int DIST_W     = 16;
    localparam int QUO_W      = LIM_W;             // quotient never exceeds the limit
    localparam int PROD_W     = MAG_W + LIM_W;
    localparam int ALT_W      = MAG_W - DIST_FRAC; // unscaled magnitude
    localparam int RAW_SHIFT  = FRAC_BITS + DIST_FRAC;
    localparam int WHEEL_W    = 18;
    localparam int DIV_STEPS  = QUO_W;
    localparam int PRE_STAGES = 5;
    localparam int NPIPE      = PRE_STAGES + DIV_STEPS;

    localparam int S_DATA_W   = 3 * IN_W;
    localparam int M_DATA_W   = N_WHEEL * WHEEL_W;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // register index codes, paddr[3:2]
    localparam logic [1:0] REG_RAW_MODE        = 2'd0;
    localparam logic [1:0] REG_WHEEL_TO_CENTER = 2'd1;
    localparam logic [1:0] REG_MAX_WHEEL_SPEED = 2'd2;

    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [ROT_W-1:0]   rot_t;
    typedef logic signed [WSUM_W-1:0]  wsum_t;
    typedef logic        [MAG_W-1:0]   mag_t;
    typedef logic        [QUO_W-1:0]   quo_t;
    typedef logic        [ALT_W-1:0]   alt_t;
    typedef logic        [PROD_W-1:0]  prod_t;
    typedef logic signed [WHEEL_W-1:0] wheel_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mecanum_wheel_mixer_normalize.sv -----
// Throughput: one transaction per cycle unless m_tready back-pressure stalls the output; 20 pipeline
// stages (sums, mix, abs, peak, multiply, then a 15-stage restoring divider, one quotient bit per
// stage) and the output register all advance independently, so bubbles collapse and input is taken
// while a result waits.
// Reset (aresetn low, synchronous) clears all valid bits and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module mecanum_wheel_mixer_normalize (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // vel_x [15:0], vel_y [31:16], rot_z [47:32]
    input  wire logic [mwmn_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // wheel_a [17:0], wheel_b [35:18], wheel_c [53:36], wheel_d [71:54]
    output logic [mwmn_pkg::M_DATA_W-1:0]      m_tdata,
    // was_scaled [0]
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mwmn_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [mwmn_pkg::PDATA_W-1:0]  pwdata,
    output logic [mwmn_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int NW  = mwmn_pkg::N_WHEEL;
    localparam int NP  = mwmn_pkg::NPIPE;
    localparam int PRE = mwmn_pkg::PRE_STAGES;
    localparam int DS  = mwmn_pkg::DIV_STEPS;
    localparam int MW  = mwmn_pkg::MAG_W;
    localparam int QW  = mwmn_pkg::QUO_W;
    localparam int AW  = mwmn_pkg::ALT_W;
    localparam int WW  = mwmn_pkg::WHEEL_W;
    localparam int PW  = mwmn_pkg::PROD_W;

    // ---------------- configuration ----------------
    logic                            raw_mode_reg;
    logic [mwmn_pkg::DIST_W-1:0]     wheel_to_center_reg;
    logic [mwmn_pkg::LIM_W-1:0]      max_wheel_speed_reg;
    logic                            cfg_wr;
    mwmn_pkg::mag_t                  limit_ext;

    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite & pready;
    assign limit_ext = MW'({max_wheel_speed_reg, {mwmn_pkg::DIST_FRAC{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_mode_reg        <= 1'b1;
            wheel_to_center_reg <= 16'd13107;
            max_wheel_speed_reg <= 15'd16384;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                mwmn_pkg::REG_RAW_MODE:        raw_mode_reg        <= pwdata[0];
                mwmn_pkg::REG_WHEEL_TO_CENTER: wheel_to_center_reg <= pwdata[15:0];
                mwmn_pkg::REG_MAX_WHEEL_SPEED: max_wheel_speed_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            mwmn_pkg::REG_RAW_MODE:        prdata = {31'd0, raw_mode_reg};
            mwmn_pkg::REG_WHEEL_TO_CENTER: prdata = {16'd0, wheel_to_center_reg};
            mwmn_pkg::REG_MAX_WHEEL_SPEED: prdata = {17'd0, max_wheel_speed_reg};
            default:                       prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    logic [NP-1:0] vld_reg;
    logic [NP-1:0] adv;
    logic          out_adv;
    logic          m_tvalid_reg;

    assign out_adv = ~m_tvalid_reg | m_tready;

    // a stage loads when it is empty or its successor loads
    always_comb begin
        adv[NP-1] = ~vld_reg[NP-1] | out_adv;
        for (int k = NP - 2; k >= 0; k--) begin
            adv[k] = ~vld_reg[k] | adv[k+1];
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= s_tvalid;
            for (int k = 1; k < NP; k++) begin
                if (adv[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ---------------- stage 1: lateral sums and rotation term ----------------
    mwmn_pkg::sum_t p_a_reg;   // -vx - vy
    mwmn_pkg::sum_t p_b_reg;   //  vx - vy
    mwmn_pkg::rot_t rot_reg;
    logic signed [mwmn_pkg::IN_W-1:0] vx, vy, wz;

    assign vx = s_tdata[15:0];
    assign vy = s_tdata[31:16];
    assign wz = s_tdata[47:32];

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            p_a_reg <= -mwmn_pkg::SUM_W'(vx) - mwmn_pkg::SUM_W'(vy);
            p_b_reg <= mwmn_pkg::SUM_W'(vx) - mwmn_pkg::SUM_W'(vy);
            rot_reg <= mwmn_pkg::ROT_W'($signed({1'b0, wheel_to_center_reg}))
                       * mwmn_pkg::ROT_W'(wz);
        end
    end

    // ---------------- stage 2: exact mix ----------------
    mwmn_pkg::wsum_t w_reg [NW];
    mwmn_pkg::wsum_t wa, wb, wr;

    assign wa = mwmn_pkg::WSUM_W'(p_a_reg) <<< mwmn_pkg::DIST_FRAC;
    assign wb = mwmn_pkg::WSUM_W'(p_b_reg) <<< mwmn_pkg::DIST_FRAC;
    assign wr = mwmn_pkg::WSUM_W'(rot_reg);

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            w_reg[0] <= wr + wa;
            w_reg[1] <= wr + wb;
            w_reg[2] <= wr - wa;
            w_reg[3] <= wr - wb;
        end
    end

    // ---------------- stage 3: magnitude and sign ----------------
    mwmn_pkg::mag_t mag3_reg [NW];
    logic           neg3_reg [NW];

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            for (int i = 0; i < NW; i++) begin
                mag3_reg[i] <= w_reg[i][mwmn_pkg::WSUM_W-1] ? MW'(-w_reg[i]) : MW'(w_reg[i]);
                neg3_reg[i] <= w_reg[i][mwmn_pkg::WSUM_W-1];
            end
        end
    end

    // ---------------- stage 4: pairwise max, over-limit check ----------------
    mwmn_pkg::mag_t mag4_reg [NW];
    logic           neg4_reg [NW];
    mwmn_pkg::mag_t pair_reg [2];
    logic           scl4_reg;
    logic           over_next;

    always_comb begin
        over_next = 1'b0;
        for (int i = 0; i < NW; i++) begin
            over_next = over_next | (mag3_reg[i] > limit_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            mag4_reg    <= mag3_reg;
            neg4_reg    <= neg3_reg;
            pair_reg[0] <= (mag3_reg[0] > mag3_reg[1]) ? mag3_reg[0] : mag3_reg[1];
            pair_reg[1] <= (mag3_reg[2] > mag3_reg[3]) ? mag3_reg[2] : mag3_reg[3];
            scl4_reg    <= over_next & ~raw_mode_reg;
        end
    end

    // ---------------- stage 5 and divider: index 0 holds the dividend ----------------
    mwmn_pkg::mag_t dv_rem_reg  [0:DS][NW];
    mwmn_pkg::quo_t dv_quo_reg  [0:DS][NW];
    mwmn_pkg::alt_t dv_alt_reg  [0:DS][NW];
    logic           dv_neg_reg  [0:DS][NW];
    mwmn_pkg::mag_t dv_peak_reg [0:DS];
    logic           dv_scl_reg  [0:DS];
    mwmn_pkg::prod_t prod_next  [NW];
    mwmn_pkg::mag_t  raw_sh     [NW];
    mwmn_pkg::mag_t  frac_sh    [NW];

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            prod_next[i] = PW'(mag4_reg[i]) * PW'(max_wheel_speed_reg);
            raw_sh[i]    = mag4_reg[i] >> mwmn_pkg::RAW_SHIFT;
            frac_sh[i]   = mag4_reg[i] >> mwmn_pkg::DIST_FRAC;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[PRE-1]) begin
            for (int i = 0; i < NW; i++) begin
                dv_rem_reg[0][i] <= prod_next[i][PW-1:QW];
                dv_quo_reg[0][i] <= prod_next[i][QW-1:0];
                dv_alt_reg[0][i] <= raw_mode_reg ? raw_sh[i][AW-1:0] : frac_sh[i][AW-1:0];
                dv_neg_reg[0][i] <= neg4_reg[i];
            end
            dv_peak_reg[0] <= (pair_reg[0] > pair_reg[1]) ? pair_reg[0] : pair_reg[1];
            dv_scl_reg[0]  <= scl4_reg;
        end
    end

    // restoring division, one quotient bit per stage; remainder stays below peak
    genvar j;
    for (j = 1; j <= DS; j++) begin : g_div
        logic [MW:0] trial_next [NW];
        logic        ge_next    [NW];

        always_comb begin
            for (int i = 0; i < NW; i++) begin
                trial_next[i] = {dv_rem_reg[j-1][i], dv_quo_reg[j-1][i][QW-1]};
                ge_next[i]    = trial_next[i] >= {1'b0, dv_peak_reg[j-1]};
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[PRE-1+j]) begin
                for (int i = 0; i < NW; i++) begin
                    dv_rem_reg[j][i] <= ge_next[i]
                        ? MW'(trial_next[i] - {1'b0, dv_peak_reg[j-1]})
                        : trial_next[i][MW-1:0];
                    dv_quo_reg[j][i] <= {dv_quo_reg[j-1][i][QW-2:0], ge_next[i]};
                    dv_alt_reg[j][i] <= dv_alt_reg[j-1][i];
                    dv_neg_reg[j][i] <= dv_neg_reg[j-1][i];
                end
                dv_peak_reg[j] <= dv_peak_reg[j-1];
                dv_scl_reg[j]  <= dv_scl_reg[j-1];
            end
        end
    end

    // ---------------- output register ----------------
    mwmn_pkg::wheel_t wheel_reg [NW];
    logic             scaled_reg;
    mwmn_pkg::wheel_t mag_out   [NW];

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            mag_out[i] = dv_scl_reg[DS] ? WW'(dv_quo_reg[DS][i]) : WW'(dv_alt_reg[DS][i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_adv) begin
            m_tvalid_reg <= vld_reg[NP-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            for (int i = 0; i < NW; i++) begin
                wheel_reg[i] <= dv_neg_reg[DS][i] ? -mag_out[i] : mag_out[i];
            end
            scaled_reg <= dv_scl_reg[DS];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {wheel_reg[3], wheel_reg[2], wheel_reg[1], wheel_reg[0]};
    assign m_tuser  = scaled_reg;

endmodule

`default_nettype wire

// ----- verif/tb_mecanum_wheel_mixer_normalize.sv -----
`timescale 1ns / 1ps

module tb_mecanum_wheel_mixer_normalize;
    import mwmn_pkg::*;

    localparam int    IDLE_LIMIT      = 2000;
    localparam int    N_PHASES        = 16;
    localparam int    ITEMS_PER_PHASE = 100;
    localparam longint DIST_ONE       = 64'sd1 <<< DIST_FRAC;
    localparam longint RAW_ONE        = 64'sd1 <<< RAW_SHIFT;
    // no register behind this index; writes must be dropped
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic                      scaled;
        wheel_t [N_WHEEL-1:0]      wheel;
    } wheel_set_t;

    class wheel_scoreboard;
        bit          raw_mode;
        bit [15:0]   wheel_dist;
        bit [14:0]   limit;
        wheel_set_t  expected_q[$];
        int          mismatches;

        function new();
            raw_mode   = 1'b1;
            wheel_dist = 16'd13107;
            limit      = 15'd16384;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_RAW_MODE:        raw_mode   = value[0];
                REG_WHEEL_TO_CENTER: wheel_dist = value[15:0];
                REG_MAX_WHEEL_SPEED: limit      = value[14:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // inverse kinematics plus optional normalization, exact until the final divide
        function void note_command(logic [S_DATA_W-1:0] data);
            longint     vx, vy, wz, rot, peak, lim, mag;
            longint     mix[N_WHEEL];
            longint     res;
            wheel_set_t want;
            vx  = longint'($signed(data[15:0]));
            vy  = longint'($signed(data[31:16]));
            wz  = longint'($signed(data[47:32]));
            rot = longint'(wheel_dist) * wz;
            mix[0] = (-vx - vy) * DIST_ONE + rot;
            mix[1] = ( vx - vy) * DIST_ONE + rot;
            mix[2] = ( vx + vy) * DIST_ONE + rot;
            mix[3] = (-vx + vy) * DIST_ONE + rot;
            want.scaled = 1'b0;
            peak = 0;
            lim  = longint'(limit);
            for (int i = 0; i < N_WHEEL; i++) begin
                mag = (mix[i] < 0) ? -mix[i] : mix[i];
                if (mag > peak)
                    peak = mag;
            end
            if (!raw_mode && peak > lim * DIST_ONE)
                want.scaled = 1'b1;
            for (int i = 0; i < N_WHEEL; i++) begin
                if (raw_mode)
                    res = mix[i] / RAW_ONE;
                else if (want.scaled)
                    res = (mix[i] * lim) / peak;
                else
                    res = mix[i] / DIST_ONE;
                want.wheel[i] = res[WHEEL_W-1:0];
            end
            expected_q.push_back(want);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_wheels(logic [M_DATA_W-1:0] data, logic scaled);
            wheel_set_t want;
            wheel_t     got;
            if (expected_q.size() == 0) begin
                report_mismatch("wheel speeds with no command outstanding");
                return;
            end
            want = expected_q.pop_front();
            for (int i = 0; i < N_WHEEL; i++) begin
                got = data[i*WHEEL_W +: WHEEL_W];
                if (got !== want.wheel[i])
                    report_mismatch($sformatf("wheel %0d: got %0d, expected %0d",
                                              i, got, $signed(want.wheel[i])));
            end
            if (scaled !== want.scaled)
                report_mismatch($sformatf("was_scaled: got %b, expected %b",
                                          scaled, want.scaled));
        endtask
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    // vel_x [15:0], vel_y [31:16], rot_z [47:32]
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // wheel_a [17:0], wheel_b [35:18], wheel_c [53:36], wheel_d [71:54]
    logic [M_DATA_W-1:0]   m_tdata;
    // was_scaled [0]
    logic                  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_W-1:0]    paddr    = '0;
    logic [PDATA_W-1:0]    pwdata   = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    wheel_scoreboard sb;
    int              src_burst  = 0;
    int              sink_burst = 0;

    mecanum_wheel_mixer_normalize DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // mostly short random waits, with occasional back-to-back runs
    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 18));
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_cmd(logic [15:0] vx, logic [15:0] vy,
                                                     logic [15:0] wz);
        return {wz, vy, vx};
    endfunction

    function automatic logic [15:0] draw_velocity();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3, 4:    return 16'($urandom_range(0, 16383)) - 16'd8192;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_command(input logic [S_DATA_W-1:0] data);
        int gap;
        gap = draw_gap(src_burst);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_command(data);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop the command stream and wait until every result is back
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic run_corners();
        send_command(pack_cmd(16'h0000, 16'h0000, 16'h0000));
        send_command(pack_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_command(pack_cmd(16'h8000, 16'h8000, 16'h8000));
        send_command(pack_cmd(16'h7FFF, 16'h8000, 16'h0000));
        send_command(pack_cmd(16'h8000, 16'h7FFF, 16'h8000));
        send_command(pack_cmd(16'h0000, 16'h0000, 16'h7FFF));
        send_command(pack_cmd(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_command(pack_cmd(16'h1000, 16'h0000, 16'h0000));
        send_command(pack_cmd(16'h0000, 16'h1000, 16'hF000));
    endtask

    // result side: random back-pressure, check each transaction
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_gap(sink_burst);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_wheels(m_tdata, m_tuser);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [31:0] dist_val;
        logic [31:0] lim_val;
        sb = new();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults: raw integer mix
        run_corners();
        settle();

        // limit exactly met vs. just exceeded, no rotation term
        write_reg(REG_RAW_MODE, 32'd0);
        write_reg(REG_WHEEL_TO_CENTER, 32'd0);
        write_reg(REG_MAX_WHEEL_SPEED, 32'd4096);
        send_command(pack_cmd(16'h1000, 16'h0000, 16'h0000));
        send_command(pack_cmd(16'hF000, 16'h0000, 16'h0000));
        send_command(pack_cmd(16'h1001, 16'h0000, 16'h0000));
        send_command(pack_cmd(16'h0000, 16'h0000, 16'h0000));
        settle();

        // zero limit: anything nonzero collapses to zero with the flag set
        write_reg(REG_WHEEL_TO_CENTER, 32'd65535);
        write_reg(REG_MAX_WHEEL_SPEED, 32'd0);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_command(pack_cmd(16'h0000, 16'h0000, 16'h0000));
        send_command(pack_cmd(16'h0001, 16'h0000, 16'h0000));
        send_command(pack_cmd(16'h0000, 16'h0000, 16'hFFFF));
        settle();

        // upper pwdata bits are don't-care
        write_reg(REG_MAX_WHEEL_SPEED, 32'hFFFF_FFFF);
        run_corners();
        settle();

        for (int p = 0; p < N_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0:       dist_val = 32'd0;
                1:       dist_val = 32'd65535;
                default: dist_val = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       lim_val = 32'd0;
                1:       lim_val = 32'd32767;
                2:       lim_val = 32'd1;
                3, 4:    lim_val = $urandom_range(0, 4095);
                default: lim_val = $urandom;
            endcase
            write_reg(REG_RAW_MODE, {31'd0, $urandom_range(0, 3) == 0});
            write_reg(REG_WHEEL_TO_CENTER, dist_val);
            write_reg(REG_MAX_WHEEL_SPEED, lim_val);
            repeat (ITEMS_PER_PHASE)
                send_command(pack_cmd(draw_velocity(), draw_velocity(), draw_velocity()));
            settle();
        end

        // catch any stray trailing result
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
